>>> rtl/drm_pkg.sv
// Package for the drip rate meter: phase, sequencer, result kind and register index codes,
// together with the fixed field widths and constants.
// Has no dependencies; used by rtl/drip_rate_meter.sv.
package drm_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DROP,
    PH_ALARM,
    PH_HALT
  } phase_t;

  typedef enum logic [3:0] {
    SQ_READY,
    SQ_EVENT,
    SQ_PCHK,
    SQ_SCHK,
    SQ_SECS,
    SQ_FACT,
    SQ_MUL,
    SQ_QUO,
    SQ_REPORT,
    SQ_OVF
  } seq_t;

  typedef enum logic [2:0] {
    KIND_DROP    = 3'd0,
    KIND_SPEED   = 3'd1,
    KIND_AVERAGE = 3'd2,
    KIND_ALARM   = 3'd3,
    KIND_RESUMED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_COUNT_MODE   = 2'd0,
    REG_DROPS_PER_ML = 2'd1,
    REG_PERIOD_MS    = 2'd2,
    REG_WARNING_MS   = 2'd3
  } reg_idx_t;

  localparam int VALUE_W  = 15;
  localparam int SECS_W   = 23;
  localparam int FACTOR_W = 12;
  localparam int CFG_W    = 16;

  localparam logic [VALUE_W-1:0]  VALUE_MAX = 15'h7FFF;
  localparam logic [SECS_W-1:0]   SECS_MAX  = 23'h7FFFFF;
  localparam logic [FACTOR_W-1:0] ML_FACTOR_NUM = 12'd3600;
  localparam logic [FACTOR_W-1:0] DPM_FACTOR    = 12'd60;
  localparam logic [9:0]          MS_PER_S      = 10'd1000;

  localparam logic [7:0]  DPML_RESET   = 8'd20;
  localparam logic [15:0] PERIOD_RESET = 16'd5000;
  localparam logic [15:0] WARN_RESET   = 16'd3000;

endpackage

>>> rtl/drip_rate_meter.sv
// Drip rate meter: counts drops from 1 ms sensor ticks, reports flow speed and average,
// and raises a blocked alarm. Depends on rtl/drm_pkg.sv.
//
// Usage. Each request on the in_ channel is one 1 ms tick carrying the sensor level, the
// active-low resume button and a stop request. Each tick gives zero to three results on the
// out_ channel, the final one marked by out_tlast; out_tuser carries the result kind.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Throughput: one tick at a time. A speed or average report runs a bit-serial sequence
// through one shared restoring divider and a shift-add multiplier: the seconds, then the
// rate factor (drops-per-ml mode only), the product and the quotient; when the seconds are
// zero the sequence ends after the seconds. A stop request served after a speed report in
// the same tick runs the sequence a second time.
// Results leave through a single output register; a new tick is taken while the last result
// of the previous one still waits there. When the receiver stalls, the sequencer holds at
// the next result until the register frees.
// Reset: registers return to their defaults, timers and counts clear and the meter waits for
// a drop. After an average report the meter halts and ignores ticks until the next reset.
module drip_rate_meter #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] sensor_level, [1] resume_button_n, [2] stop_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [14:0] value, [37:15] run_seconds, [38] error_flag
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CW   = COUNT_WIDTH;
  localparam int TW   = TIME_WIDTH;
  localparam int FW   = drm_pkg::FACTOR_W;
  localparam int SW   = TW - 9;
  localparam int PW   = CW + FW;
  localparam int NW   = (TW > PW) ? TW : PW;
  localparam int RW   = ((SW > 10) ? SW : 10) + 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int VW   = drm_pkg::VALUE_W;
  localparam int XW   = drm_pkg::SECS_W;
  localparam int VXW  = (CW > VW) ? CW : VW;
  localparam int SXW  = (SW > XW) ? SW : XW;

  drm_pkg::seq_t   seq_r, seq_nxt;
  drm_pkg::phase_t phase_r, phase_nxt;
  logic            aid_r, aid_nxt;
  logic            stop_r, stop_nxt;
  logic [TW-1:0]   blocked_r, blocked_nxt;
  logic [TW-1:0]   period_r, period_nxt;
  logic [TW-1:0]   run_r, run_nxt;
  logic [CW-1:0]   pdrops_r, pdrops_nxt;
  logic [CW-1:0]   tdrops_r, tdrops_nxt;

  logic            mode_r, mode_nxt;
  logic [7:0]      dpm_r, dpm_nxt;
  logic [15:0]     period_ms_r, period_ms_nxt;
  logic [15:0]     warn_ms_r, warn_ms_nxt;

  drm_pkg::kind_t  ev_kind_r, ev_kind_nxt;
  logic            ev_last_r, ev_last_nxt;
  logic            ev_chk_r, ev_chk_nxt;
  logic            op_avg_r, op_avg_nxt;
  logic            zero_r, zero_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   div_r, div_nxt;
  logic [SW-1:0]   secs_r, secs_nxt;
  logic [FW-1:0]   fac_r, fac_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [CW-1:0]   drops_r, drops_nxt;

  logic            out_valid_r, out_valid_nxt;
  drm_pkg::kind_t  out_kind_r, out_kind_nxt;
  logic [VW-1:0]   out_value_r, out_value_nxt;
  logic [XW-1:0]   out_secs_r, out_secs_nxt;
  logic            out_err_r, out_err_nxt;
  logic            out_last_r, out_last_nxt;

  logic            in_acc, slot_free, cnt_last;
  logic            lvl, btn_n, stp, stop_tk, more, period_due;
  logic [TW-1:0]   run_inc, per_inc, blk_inc;
  logic            tk_evt, tk_chk, tk_last;
  drm_pkg::kind_t  tk_kind;
  drm_pkg::phase_t tk_phase;
  logic [RW-1:0]   step_sh;
  logic            step_ge;
  logic [RW-1:0]   step_rem;
  logic [NW-1:0]   step_num;
  logic [PW-1:0]   quo;
  logic            ovf, ovf_eff;
  logic [VW-1:0]   rate_value, pd_sat;
  logic [VXW-1:0]  pd_x;
  logic [SXW-1:0]  secs_x;
  logic [XW-1:0]   secs_sat;

  assign in_tready  = (seq_r == drm_pkg::SQ_READY);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign cnt_last   = (cnt_r == CNTW'(1));
  assign lvl        = in_tdata[0];
  assign btn_n      = in_tdata[1];
  assign stp        = in_tdata[2];

  assign run_inc    = (&run_r) ? run_r : run_r + TW'(1);
  assign per_inc    = (&period_r) ? period_r : period_r + TW'(1);
  assign blk_inc    = (&blocked_r) ? blocked_r : blocked_r + TW'(1);
  assign stop_tk    = stop_r || stp;
  assign more       = (per_inc >= TW'(period_ms_r)) || stop_tk;
  assign period_due = (period_r >= TW'(period_ms_r));

  assign step_sh    = {rem_r[RW-2:0], num_r[NW-1]};
  assign step_ge    = (step_sh >= div_r);
  assign step_rem   = step_ge ? step_sh - div_r : step_sh;
  assign step_num   = {num_r[NW-2:0], step_ge};

  assign quo        = num_r[PW-1:0];
  assign ovf        = |quo[PW-1:VW];
  assign ovf_eff    = !zero_r && ovf;
  assign rate_value = zero_r ? '0 : (ovf ? drm_pkg::VALUE_MAX : quo[VW-1:0]);

  assign pd_x       = VXW'(pdrops_r);
  assign pd_sat     = (pd_x > VXW'(drm_pkg::VALUE_MAX)) ? drm_pkg::VALUE_MAX : pd_x[VW-1:0];
  assign secs_x     = SXW'(secs_r);
  assign secs_sat   = (secs_x > SXW'(drm_pkg::SECS_MAX)) ? drm_pkg::SECS_MAX : secs_x[XW-1:0];

  // Decode of one tick against the current phase.
  always_comb begin
    tk_evt   = 1'b0;
    tk_chk   = 1'b0;
    tk_last  = 1'b1;
    tk_kind  = drm_pkg::KIND_DROP;
    tk_phase = phase_r;
    case (phase_r)
      drm_pkg::PH_ALARM: begin
        if (!btn_n) begin
          tk_evt   = 1'b1;
          tk_kind  = drm_pkg::KIND_RESUMED;
          tk_phase = aid_r ? drm_pkg::PH_DROP : drm_pkg::PH_IDLE;
        end
      end
      drm_pkg::PH_DROP: begin
        if (!lvl) begin
          tk_evt   = 1'b1;
          tk_kind  = drm_pkg::KIND_DROP;
          tk_last  = !more;
          tk_chk   = more;
          tk_phase = drm_pkg::PH_IDLE;
        end else if (blk_inc >= TW'(warn_ms_r)) begin
          tk_evt   = 1'b1;
          tk_kind  = drm_pkg::KIND_ALARM;
          tk_phase = drm_pkg::PH_ALARM;
        end
      end
      drm_pkg::PH_IDLE: begin
        if (lvl) begin
          tk_phase = drm_pkg::PH_DROP;
        end else begin
          tk_chk = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      drm_pkg::SQ_READY: begin
        if (in_acc) begin
          if (tk_evt) begin
            seq_nxt = drm_pkg::SQ_EVENT;
          end else if (tk_chk) begin
            seq_nxt = drm_pkg::SQ_PCHK;
          end
        end
      end
      drm_pkg::SQ_EVENT: begin
        if (slot_free) begin
          seq_nxt = ev_chk_r ? drm_pkg::SQ_PCHK : drm_pkg::SQ_READY;
        end
      end
      drm_pkg::SQ_PCHK: begin
        seq_nxt = period_due ? drm_pkg::SQ_SECS : drm_pkg::SQ_SCHK;
      end
      drm_pkg::SQ_SCHK: begin
        seq_nxt = stop_r ? drm_pkg::SQ_SECS : drm_pkg::SQ_READY;
      end
      drm_pkg::SQ_SECS: begin
        if (cnt_last) begin
          if (zero_r) begin
            seq_nxt = drm_pkg::SQ_REPORT;
          end else begin
            seq_nxt = mode_r ? drm_pkg::SQ_MUL : drm_pkg::SQ_FACT;
          end
        end
      end
      drm_pkg::SQ_FACT: begin
        if (cnt_last) begin
          seq_nxt = drm_pkg::SQ_MUL;
        end
      end
      drm_pkg::SQ_MUL: begin
        if (cnt_last) begin
          seq_nxt = drm_pkg::SQ_QUO;
        end
      end
      drm_pkg::SQ_QUO: begin
        if (cnt_last) begin
          seq_nxt = drm_pkg::SQ_REPORT;
        end
      end
      drm_pkg::SQ_REPORT: begin
        if (slot_free) begin
          if (op_avg_r) begin
            seq_nxt = drm_pkg::SQ_READY;
          end else begin
            seq_nxt = ovf_eff ? drm_pkg::SQ_OVF : drm_pkg::SQ_SCHK;
          end
        end
      end
      drm_pkg::SQ_OVF: begin
        if (slot_free) begin
          seq_nxt = drm_pkg::SQ_READY;
        end
      end
      default: begin
        seq_nxt = drm_pkg::SQ_READY;
      end
    endcase
  end

  // Sequencer outputs: configuration writes, state updates, serial datapath and the result register.
  always_comb begin
    phase_nxt     = phase_r;
    aid_nxt       = aid_r;
    stop_nxt      = stop_r;
    blocked_nxt   = blocked_r;
    period_nxt    = period_r;
    run_nxt       = run_r;
    pdrops_nxt    = pdrops_r;
    tdrops_nxt    = tdrops_r;
    mode_nxt      = mode_r;
    dpm_nxt       = dpm_r;
    period_ms_nxt = period_ms_r;
    warn_ms_nxt   = warn_ms_r;
    ev_kind_nxt   = ev_kind_r;
    ev_last_nxt   = ev_last_r;
    ev_chk_nxt    = ev_chk_r;
    op_avg_nxt    = op_avg_r;
    zero_nxt      = zero_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    secs_nxt      = secs_r;
    fac_nxt       = fac_r;
    prod_nxt      = prod_r;
    drops_nxt     = drops_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_secs_nxt  = out_secs_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      case (drm_pkg::reg_idx_t'(cfg_addr))
        drm_pkg::REG_COUNT_MODE:   mode_nxt      = cfg_wdata[0];
        drm_pkg::REG_DROPS_PER_ML: dpm_nxt       = cfg_wdata[7:0];
        drm_pkg::REG_PERIOD_MS:    period_ms_nxt = cfg_wdata;
        drm_pkg::REG_WARNING_MS:   warn_ms_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end

    case (seq_r)
      drm_pkg::SQ_READY: begin
        if (in_acc && (phase_r != drm_pkg::PH_HALT)) begin
          stop_nxt    = stop_tk;
          run_nxt     = run_inc;
          period_nxt  = per_inc;
          phase_nxt   = tk_phase;
          ev_kind_nxt = tk_kind;
          ev_last_nxt = tk_last;
          ev_chk_nxt  = tk_chk;
          if (phase_r == drm_pkg::PH_DROP) begin
            blocked_nxt = blk_inc;
            if (!lvl) begin
              pdrops_nxt = (&pdrops_r) ? pdrops_r : pdrops_r + CW'(1);
              tdrops_nxt = (&tdrops_r) ? tdrops_r : tdrops_r + CW'(1);
            end else if (tk_phase == drm_pkg::PH_ALARM) begin
              aid_nxt = 1'b1;
            end
          end else if ((phase_r == drm_pkg::PH_IDLE) && lvl) begin
            blocked_nxt = '0;
          end
        end
      end
      drm_pkg::SQ_EVENT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ev_kind_r;
          out_value_nxt = (ev_kind_r == drm_pkg::KIND_DROP) ? pd_sat : '0;
          out_secs_nxt  = '0;
          out_err_nxt   = 1'b0;
          out_last_nxt  = ev_last_r;
        end
      end
      drm_pkg::SQ_PCHK: begin
        op_avg_nxt = 1'b0;
        zero_nxt   = (period_r < TW'(drm_pkg::MS_PER_S));
        num_nxt    = NW'(period_r) << (NW - TW);
        rem_nxt    = '0;
        div_nxt    = RW'(drm_pkg::MS_PER_S);
        cnt_nxt    = CNTW'(TW);
        drops_nxt  = pdrops_r;
      end
      drm_pkg::SQ_SCHK: begin
        op_avg_nxt = 1'b1;
        zero_nxt   = (run_r < TW'(drm_pkg::MS_PER_S));
        num_nxt    = NW'(run_r) << (NW - TW);
        rem_nxt    = '0;
        div_nxt    = RW'(drm_pkg::MS_PER_S);
        cnt_nxt    = CNTW'(TW);
        drops_nxt  = tdrops_r;
      end
      drm_pkg::SQ_SECS: begin
        num_nxt = step_num;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_last) begin
          secs_nxt = step_num[SW-1:0];
          prod_nxt = '0;
          cnt_nxt  = CNTW'(FW);
          if (mode_r) begin
            fac_nxt = drm_pkg::DPM_FACTOR;
          end else begin
            num_nxt = NW'(drm_pkg::ML_FACTOR_NUM) << (NW - FW);
            rem_nxt = '0;
            div_nxt = RW'((dpm_r == 8'd0) ? 8'd1 : dpm_r);
          end
        end
      end
      drm_pkg::SQ_FACT: begin
        num_nxt = step_num;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_last) begin
          fac_nxt = step_num[FW-1:0];
          cnt_nxt = CNTW'(FW);
        end
      end
      drm_pkg::SQ_MUL: begin
        prod_nxt = {prod_r[PW-2:0], 1'b0} + (fac_r[FW-1] ? PW'(drops_r) : '0);
        fac_nxt  = {fac_r[FW-2:0], 1'b0};
        cnt_nxt  = cnt_r - CNTW'(1);
        if (cnt_last) begin
          num_nxt = NW'(prod_nxt) << (NW - PW);
          rem_nxt = '0;
          div_nxt = RW'(secs_r);
          cnt_nxt = CNTW'(PW);
        end
      end
      drm_pkg::SQ_QUO: begin
        num_nxt = step_num;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r - CNTW'(1);
      end
      drm_pkg::SQ_REPORT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rate_value;
          out_err_nxt   = zero_r || ovf;
          if (op_avg_r) begin
            out_kind_nxt = drm_pkg::KIND_AVERAGE;
            out_secs_nxt = secs_sat;
            out_last_nxt = 1'b1;
            phase_nxt    = drm_pkg::PH_HALT;
            stop_nxt     = 1'b0;
          end else begin
            out_kind_nxt = drm_pkg::KIND_SPEED;
            out_secs_nxt = '0;
            out_last_nxt = !(ovf_eff || stop_r);
            period_nxt   = '0;
            pdrops_nxt   = '0;
          end
        end
      end
      drm_pkg::SQ_OVF: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = drm_pkg::KIND_ALARM;
          out_value_nxt = drm_pkg::VALUE_MAX;
          out_secs_nxt  = '0;
          out_err_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          phase_nxt     = drm_pkg::PH_ALARM;
          aid_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= drm_pkg::SQ_READY;
      phase_r     <= drm_pkg::PH_IDLE;
      aid_r       <= 1'b0;
      stop_r      <= 1'b0;
      blocked_r   <= '0;
      period_r    <= '0;
      run_r       <= '0;
      pdrops_r    <= '0;
      tdrops_r    <= '0;
      mode_r      <= 1'b0;
      dpm_r       <= drm_pkg::DPML_RESET;
      period_ms_r <= drm_pkg::PERIOD_RESET;
      warn_ms_r   <= drm_pkg::WARN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      aid_r       <= aid_nxt;
      stop_r      <= stop_nxt;
      blocked_r   <= blocked_nxt;
      period_r    <= period_nxt;
      run_r       <= run_nxt;
      pdrops_r    <= pdrops_nxt;
      tdrops_r    <= tdrops_nxt;
      mode_r      <= mode_nxt;
      dpm_r       <= dpm_nxt;
      period_ms_r <= period_ms_nxt;
      warn_ms_r   <= warn_ms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_kind_r   <= ev_kind_nxt;
    ev_last_r   <= ev_last_nxt;
    ev_chk_r    <= ev_chk_nxt;
    op_avg_r    <= op_avg_nxt;
    zero_r      <= zero_nxt;
    cnt_r       <= cnt_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    secs_r      <= secs_nxt;
    fac_r       <= fac_nxt;
    prod_r      <= prod_nxt;
    drops_r     <= drops_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_secs_r  <= out_secs_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_err_r, out_secs_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Once halted, the meter stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == drm_pkg::PH_HALT) |=> (phase_r == drm_pkg::PH_HALT))
    else $error("halted phase was left without reset");

  // A tick taken while halted leaves the run timer unchanged.
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_r == drm_pkg::PH_HALT)) |=> $stable(run_r))
    else $error("run timer moved while halted");

  // No stop request stays pending once the average has been reported.
  a_stop_served: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == drm_pkg::PH_HALT) |-> !stop_r)
    else $error("stop request pending in halted phase");

  // Run seconds are only carried by the average report.
  a_secs_avg_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != drm_pkg::KIND_AVERAGE)) |-> (out_secs_r == '0))
    else $error("run seconds on a result other than the average");

  // Drop, resume and blocked results never carry an error.
  a_err_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      ((out_kind_r == drm_pkg::KIND_SPEED) || (out_kind_r == drm_pkg::KIND_AVERAGE) ||
       ((out_kind_r == drm_pkg::KIND_ALARM) && (out_value_r == drm_pkg::VALUE_MAX))))
    else $error("error flag on a result that cannot fail");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for drip_rate_meter: streams 1 ms sensor ticks through the block
// and checks every result against a cycle-free model of the meter kept alongside.
// Depends on rtl/drm_pkg.sv and rtl/drip_rate_meter.sv.
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic level;
    logic button_n;
    logic stop;
  } tick_t;

  typedef struct {
    drm_pkg::kind_t              kind;
    logic [drm_pkg::VALUE_W-1:0] value;
    logic [drm_pkg::SECS_W-1:0]  secs;
    logic                        err;
    logic                        last;
  } report_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;

  drip_rate_meter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tick_t   ticks_to_send[$];
  report_t expected_reports[$];
  report_t tick_results[$];
  tick_t   on_bus;
  int      ticks_queued   = 0;
  int      ticks_accepted = 0;
  int      results_seen   = 0;
  int      mismatches     = 0;
  int      kind_seen[0:4] = '{default: 0};

  // Shadow of the meter state and its registers.
  drm_pkg::phase_t meter_phase    = drm_pkg::PH_IDLE;
  logic [31:0]     blocked_ms     = '0;
  logic [31:0]     period_elapsed = '0;
  logic [31:0]     run_elapsed    = '0;
  logic [15:0]     period_drops   = '0;
  logic [15:0]     total_drops    = '0;
  logic            stop_latched   = 1'b0;
  logic            alarm_in_drop  = 1'b0;
  logic            mode_dpm       = 1'b0;
  logic [7:0]      dpml_reg       = drm_pkg::DPML_RESET;
  logic [15:0]     period_reg     = drm_pkg::PERIOD_RESET;
  logic [15:0]     warn_reg       = drm_pkg::WARN_RESET;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic longint unsigned meter_factor();
    if (mode_dpm) return longint'(drm_pkg::DPM_FACTOR);
    return drm_pkg::ML_FACTOR_NUM / ((dpml_reg == 8'd0) ? 8'd1 : dpml_reg);
  endfunction

  task automatic compute_rate(input longint unsigned drops, input longint unsigned secs,
                              output logic [drm_pkg::VALUE_W-1:0] v, output logic err,
                              output logic ovf);
    longint unsigned q;
    err = 1'b0;
    ovf = 1'b0;
    v   = '0;
    if (secs == 0) begin
      err = 1'b1;
    end else begin
      q = drops * meter_factor() / secs;
      if (q > drm_pkg::VALUE_MAX) begin
        v   = drm_pkg::VALUE_MAX;
        err = 1'b1;
        ovf = 1'b1;
      end else begin
        v = q[drm_pkg::VALUE_W-1:0];
      end
    end
  endtask

  task automatic post(input drm_pkg::kind_t k, input logic [drm_pkg::VALUE_W-1:0] v,
                      input logic [drm_pkg::SECS_W-1:0] s, input logic e);
    report_t r;
    r.kind  = k;
    r.value = v;
    r.secs  = s;
    r.err   = e;
    r.last  = 1'b0;
    tick_results.push_back(r);
  endtask

  task automatic period_and_stop_checks();
    logic [drm_pkg::VALUE_W-1:0] v;
    logic                        err;
    logic                        ovf;
    longint unsigned             secs;
    if (period_elapsed >= period_reg) begin
      compute_rate(period_drops, period_elapsed / 1000, v, err, ovf);
      period_elapsed = '0;
      period_drops   = '0;
      post(drm_pkg::KIND_SPEED, v, '0, err);
      if (ovf) begin
        post(drm_pkg::KIND_ALARM, drm_pkg::VALUE_MAX, '0, 1'b1);
        meter_phase   = drm_pkg::PH_ALARM;
        alarm_in_drop = 1'b0;
        return;
      end
    end
    if (stop_latched) begin
      secs = run_elapsed / 1000;
      compute_rate(total_drops, secs, v, err, ovf);
      post(drm_pkg::KIND_AVERAGE, v,
           (secs > drm_pkg::SECS_MAX) ? drm_pkg::SECS_MAX : secs[drm_pkg::SECS_W-1:0], err);
      meter_phase  = drm_pkg::PH_HALT;
      stop_latched = 1'b0;
    end
  endtask

  task automatic predict_meter_tick(input tick_t t);
    tick_results.delete();
    if (meter_phase == drm_pkg::PH_HALT) return;
    if (t.stop) stop_latched = 1'b1;
    run_elapsed    = sat_inc(run_elapsed);
    period_elapsed = sat_inc(period_elapsed);
    case (meter_phase)
      drm_pkg::PH_ALARM: begin
        if (!t.button_n) begin
          post(drm_pkg::KIND_RESUMED, '0, '0, 1'b0);
          meter_phase = alarm_in_drop ? drm_pkg::PH_DROP : drm_pkg::PH_IDLE;
        end
      end
      drm_pkg::PH_DROP: begin
        blocked_ms = sat_inc(blocked_ms);
        if (!t.level) begin
          if (period_drops != '1) period_drops++;
          if (total_drops != '1) total_drops++;
          post(drm_pkg::KIND_DROP, (period_drops > drm_pkg::VALUE_MAX) ?
               drm_pkg::VALUE_MAX : period_drops[drm_pkg::VALUE_W-1:0], '0, 1'b0);
          meter_phase = drm_pkg::PH_IDLE;
          period_and_stop_checks();
        end else if (blocked_ms >= warn_reg) begin
          post(drm_pkg::KIND_ALARM, '0, '0, 1'b0);
          meter_phase   = drm_pkg::PH_ALARM;
          alarm_in_drop = 1'b1;
        end
      end
      default: begin
        if (t.level) begin
          meter_phase = drm_pkg::PH_DROP;
          blocked_ms  = '0;
        end else begin
          period_and_stop_checks();
        end
      end
    endcase
    if (tick_results.size() > 0) tick_results[tick_results.size()-1].last = 1'b1;
    foreach (tick_results[i]) expected_reports.push_back(tick_results[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result();
    report_t want;
    if (out_tuser <= 3'd4) kind_seen[out_tuser]++;
    results_seen++;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("kind %0d value %0d arrived with nothing pending",
                                out_tuser, out_tdata[14:0]));
      return;
    end
    want = expected_reports.pop_front();
    if (out_tuser !== want.kind || out_tdata[14:0] !== want.value ||
        out_tdata[37:15] !== want.secs || out_tdata[38] !== want.err ||
        out_tlast !== want.last) begin
      report_mismatch($sformatf(
        "got kind %0d value %0d secs %0d err %0b last %0b, want %0d %0d %0d %0b %0b",
        out_tuser, out_tdata[14:0], out_tdata[37:15], out_tdata[38], out_tlast,
        want.kind, want.value, want.secs, want.err, want.last));
    end
  endtask

  always @(posedge clk) begin : drive_ticks
    int idle_left;
    int drv_quiet;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_meter_tick(on_bus);
        ticks_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 1'b0;
        end else if (ticks_to_send.size() > 0) begin
          on_bus = ticks_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, on_bus.stop, on_bus.button_n, on_bus.level};
          if (drv_quiet > 0) begin
            drv_quiet--;
            idle_left = 0;
          end else begin
            idle_left = gap_len();
            if ($urandom_range(0, 49) == 0) drv_quiet = $urandom_range(5, 15);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    int hold_left;
    int mon_quiet;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (mon_quiet > 0) begin
        mon_quiet--;
        out_tready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) hold_left = gap_len();
        else if ($urandom_range(0, 499) == 0) mon_quiet = $urandom_range(100, 400);
      end
    end
  end

  task automatic add_tick(input logic level, input logic button_n, input logic stop);
    tick_t t;
    t.level    = level;
    t.button_n = button_n;
    t.stop     = stop;
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  task automatic add_noisy(input logic level);
    add_tick(level, $urandom_range(0, 5) != 0, 1'b0);
  endtask

  task automatic add_drop(input int hi, input int lo);
    repeat (hi) add_noisy(1'b1);
    repeat (lo) add_noisy(1'b0);
  endtask

  task automatic random_traffic(input int n, input int max_hi, input int max_lo);
    int first;
    int r;
    first = ticks_queued;
    while (ticks_queued - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) add_drop($urandom_range(1, max_hi), $urandom_range(1, max_lo));
      else if (r < 92) repeat ($urandom_range(1, 2 * max_lo)) add_noisy(1'b0);
      else add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic wait_for_quiet();
    while (ticks_accepted != ticks_queued || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input drm_pkg::reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      drm_pkg::REG_COUNT_MODE:   mode_dpm   = val[0];
      drm_pkg::REG_DROPS_PER_ML: dpml_reg   = val[7:0];
      drm_pkg::REG_PERIOD_MS:    period_reg = val;
      drm_pkg::REG_WARNING_MS:   warn_reg   = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults.
    random_traffic(28, 4, 6);
    wait_for_quiet();

    write_reg(drm_pkg::REG_COUNT_MODE, 16'd0);
    write_reg(drm_pkg::REG_DROPS_PER_ML, 16'd1);
    write_reg(drm_pkg::REG_PERIOD_MS, 16'd1000);
    write_reg(drm_pkg::REG_WARNING_MS, 16'd1);
    end_writes();
    // A blocked alarm, a silent alarm tick, resume back into the drop, a repeated alarm and a
    // second resume, then a counted drop and a burst of short drops with the button pressed on their high ticks.
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b1, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b0, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b0);
    repeat (8) begin
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b0, 1'b1, 1'b0);
    end
    random_traffic(22, 3, 5);
    wait_for_quiet();

    write_reg(drm_pkg::REG_COUNT_MODE, 16'd1);
    write_reg(drm_pkg::REG_DROPS_PER_ML, 16'd255);
    write_reg(drm_pkg::REG_PERIOD_MS, 16'd1999);
    write_reg(drm_pkg::REG_WARNING_MS, 16'd3);
    end_writes();
    random_traffic(24, 6, 4);
    wait_for_quiet();

    write_reg(drm_pkg::REG_COUNT_MODE, 16'($urandom_range(0, 1)));
    write_reg(drm_pkg::REG_DROPS_PER_ML, 16'($urandom_range(1, 255)));
    write_reg(drm_pkg::REG_PERIOD_MS, 16'($urandom_range(1000, 3000)));
    write_reg(drm_pkg::REG_WARNING_MS, 16'($urandom_range(1, 8)));
    end_writes();
    random_traffic(18, 5, 6);
    // Stop request, ticks that let it be served, then ticks the halted meter must ignore.
    add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    repeat (4) add_tick(1'b0, 1'b0, 1'b0);
    repeat (6) begin
      add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    wait_for_quiet();

    $display("Sent %0d ticks across four register settings and checked %0d results.",
             ticks_accepted, results_seen);
    $display("Drops %0d, speed %0d, average %0d, alarms %0d, resumes %0d; mismatches %0d.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
